/* rtl/itp_pkg.sv */
// Shared codes, defaults and the precedence function of the infix-to-postfix converter.
// Used by the operator stack memory and the top level. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   typedef logic [2:0] op_type;
   typedef logic [1:0] kind_type;
   typedef logic [1:0] err_type;
   typedef logic [1:0] rank_type;

   // Input token kinds.
   localparam kind_type TOK_OPERAND  = 2'd0;
   localparam kind_type TOK_OPERATOR = 2'd1;
   localparam kind_type TOK_END      = 2'd2;

   // Result kinds.
   localparam kind_type OUT_OPERAND  = 2'd0;
   localparam kind_type OUT_OPERATOR = 2'd1;
   localparam kind_type OUT_END      = 2'd2;
   localparam kind_type OUT_ERROR    = 2'd3;

   // Operator codes.
   localparam op_type OP_PLUS   = 3'd0;
   localparam op_type OP_MINUS  = 3'd1;
   localparam op_type OP_TIMES  = 3'd2;
   localparam op_type OP_DIVIDE = 3'd3;
   localparam op_type OP_POWER  = 3'd4;
   localparam op_type OP_OPEN   = 3'd5;
   localparam op_type OP_CLOSE  = 3'd6;

   // Error codes.
   localparam err_type ERR_NONE     = 2'd0;
   localparam err_type ERR_OVERFLOW = 2'd1;
   localparam err_type ERR_UNMATCH  = 2'd2;

   function automatic rank_type rank_of(op_type code);
      rank_type r;
      case (code)
         OP_PLUS, OP_MINUS:   r = 2'd1;
         OP_TIMES, OP_DIVIDE: r = 2'd2;
         default:             r = 2'd3;
      endcase
      return r;
   endfunction

endpackage

/* rtl/itp_stack_mem.sv */
// Operator stack storage: one write port, one registered read port.
// Forwards a write to the same entry into the next read. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_stack_mem #(
   parameter int DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  itp_pkg::op_type              wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output itp_pkg::op_type              rd_data
);
   import itp_pkg::*;

   op_type mem [DEPTH];
   op_type rd_q_ff;
   op_type wr_q_ff;
   logic   fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
      wr_q_ff <= wr_data;
   end

   // A read of the entry being written returns the old contents, so the new
   // value is taken from the bypass register instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? wr_q_ff : rd_q_ff;

endmodule

/* rtl/infix_to_postfix_shunting_yard.sv */
// Top level of the infix-to-postfix converter: token sequencer and output register.
// Depends on itp_pkg and itp_stack_mem.
`timescale 1ns / 1ps

// Shunting-yard converter. One infix token is taken per transfer on the req_
// channel and the postfix tokens it releases leave in order on the rsp_
// channel, with rsp_run_last marking the final result of each token. The
// operator stack lives in a synchronous memory whose top entry is read ahead
// every cycle, so a token is accepted in S_IDLE and then decided in S_RUN,
// which pops one operator per step; a run of pops that ends in an end marker
// or an error result also passes through S_DRAIN, and back pressure on
// rsp_stall can hold S_RUN and S_DRAIN. A new token is accepted only after the
// previous one has handed off its last result, which may still wait in the
// output register. The stack needs no clearing after reset.
module infix_to_postfix_shunting_yard #(
   parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH,
   parameter int VALUE_WIDTH = itp_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_token_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_value,
   input  logic [2:0]                    req_operator_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_out_kind,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_value,
   output logic [2:0]                    rsp_out_operator,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_run_last
);
   import itp_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN
   } state_type;

   state_type state_ff;

   // Latched token.
   kind_type                      tok_kind_ff;
   logic signed [VALUE_WIDTH-1:0] tok_value_ff;
   op_type                        tok_code_ff;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_m1;

   // One result held back until it is known whether it is the last one.
   logic                          hold_valid_ff;
   kind_type                      hold_kind_ff;
   logic signed [VALUE_WIDTH-1:0] hold_value_ff;
   op_type                        hold_op_ff;
   err_type                       hold_err_ff;

   // Output register.
   logic                          rsp_valid_ff;
   kind_type                      out_kind_ff;
   logic signed [VALUE_WIDTH-1:0] out_value_ff;
   op_type                        out_op_ff;
   err_type                       out_err_ff;
   logic                          out_last_ff;

   op_type  top;
   logic    stack_empty;
   logic    stack_full;
   logic    may_pop;

   logic                          r_valid;
   kind_type                      r_kind;
   logic signed [VALUE_WIDTH-1:0] r_value;
   op_type                        r_op;
   err_type                       r_err;
   logic                          step_done;
   logic                          step_pop;
   logic                          step_push;
   logic                          need_out;
   logic                          out_free;
   logic                          fire;

   logic [AW-1:0] rd_addr;

   itp_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fire && step_push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (tok_code_ff),
      .rd_addr (rd_addr),
      .rd_data (top)
   );

   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CW'(STACK_DEPTH));

   // An incoming operator releases the top when the top binds tighter, or as
   // tightly and the incoming operator is left-associative.
   assign may_pop = !stack_empty && (top != OP_OPEN) &&
                    ((rank_of(top) > rank_of(tok_code_ff)) ||
                     ((rank_of(top) == rank_of(tok_code_ff)) &&
                      (tok_code_ff != OP_POWER)));

   always_comb begin
      r_valid   = 1'b0;
      r_kind    = OUT_OPERAND;
      r_value   = '0;
      r_op      = OP_PLUS;
      r_err     = ERR_NONE;
      step_done = 1'b1;
      step_pop  = 1'b0;
      step_push = 1'b0;
      case (tok_kind_ff)
         TOK_OPERAND: begin
            r_valid = 1'b1;
            r_value = tok_value_ff;
         end
         TOK_END: begin
            r_valid = 1'b1;
            if (!stack_empty) begin
               r_kind    = OUT_OPERATOR;
               r_op      = top;
               step_pop  = 1'b1;
               step_done = 1'b0;
            end else begin
               r_kind = OUT_END;
            end
         end
         TOK_OPERATOR: begin
            if (tok_code_ff == OP_OPEN) begin
               if (!stack_full) begin
                  step_push = 1'b1;
               end else begin
                  r_valid = 1'b1;
                  r_kind  = OUT_ERROR;
                  r_err   = ERR_OVERFLOW;
               end
            end else if (tok_code_ff == OP_CLOSE) begin
               if (stack_empty) begin
                  r_valid = 1'b1;
                  r_kind  = OUT_ERROR;
                  r_err   = ERR_UNMATCH;
               end else if (top == OP_OPEN) begin
                  step_pop = 1'b1;
               end else begin
                  r_valid   = 1'b1;
                  r_kind    = OUT_OPERATOR;
                  r_op      = top;
                  step_pop  = 1'b1;
                  step_done = 1'b0;
               end
            end else if (tok_code_ff <= OP_POWER) begin
               if (may_pop) begin
                  r_valid   = 1'b1;
                  r_kind    = OUT_OPERATOR;
                  r_op      = top;
                  step_pop  = 1'b1;
                  step_done = 1'b0;
               end else if (!stack_full) begin
                  step_push = 1'b1;
               end else begin
                  r_valid = 1'b1;
                  r_kind  = OUT_ERROR;
                  r_err   = ERR_OVERFLOW;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign need_out = (hold_valid_ff && (r_valid || step_done)) ||
                     (step_done && r_valid && !hold_valid_ff);
   assign fire     = (state_ff == S_RUN) && (!need_out || out_free);

   always_comb begin
      count_in = count_ff;
      if (fire && step_pop) begin
         count_in = count_ff - CW'(1);
      end else if (fire && step_push) begin
         count_in = count_ff + CW'(1);
      end
   end

   // Address the entry that will be on top after this edge.
   assign count_m1 = count_in - CW'(1);
   assign rd_addr  = (count_in == '0) ? '0 : count_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  tok_kind_ff  <= req_token_kind;
                  tok_value_ff <= req_operand_value;
                  tok_code_ff  <= req_operator_code;
                  state_ff     <= S_RUN;
               end
            end
            S_RUN: begin
               if (fire) begin
                  if (hold_valid_ff && r_valid) begin
                     rsp_valid_ff  <= 1'b1;
                     out_kind_ff   <= hold_kind_ff;
                     out_value_ff  <= hold_value_ff;
                     out_op_ff     <= hold_op_ff;
                     out_err_ff    <= hold_err_ff;
                     out_last_ff   <= 1'b0;
                     hold_kind_ff  <= r_kind;
                     hold_value_ff <= r_value;
                     hold_op_ff    <= r_op;
                     hold_err_ff   <= r_err;
                     if (step_done) begin
                        state_ff <= S_DRAIN;
                     end
                  end else if (hold_valid_ff && step_done) begin
                     rsp_valid_ff  <= 1'b1;
                     out_kind_ff   <= hold_kind_ff;
                     out_value_ff  <= hold_value_ff;
                     out_op_ff     <= hold_op_ff;
                     out_err_ff    <= hold_err_ff;
                     out_last_ff   <= 1'b1;
                     hold_valid_ff <= 1'b0;
                     state_ff      <= S_IDLE;
                  end else if (r_valid && step_done) begin
                     rsp_valid_ff <= 1'b1;
                     out_kind_ff  <= r_kind;
                     out_value_ff <= r_value;
                     out_op_ff    <= r_op;
                     out_err_ff   <= r_err;
                     out_last_ff  <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else if (r_valid) begin
                     hold_valid_ff <= 1'b1;
                     hold_kind_ff  <= r_kind;
                     hold_value_ff <= r_value;
                     hold_op_ff    <= r_op;
                     hold_err_ff   <= r_err;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_DRAIN: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  out_kind_ff   <= hold_kind_ff;
                  out_value_ff  <= hold_value_ff;
                  out_op_ff     <= hold_op_ff;
                  out_err_ff    <= hold_err_ff;
                  out_last_ff   <= 1'b1;
                  hold_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Nothing is taken while reset is high.
   assign req_stall        = reset || (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_operator = out_op_ff;
   assign rsp_error_code   = out_err_ff;
   assign rsp_run_last     = out_last_ff;

endmodule

/* test/tb_infix_to_postfix_shunting_yard.sv */
// Self-checking testbench for the infix-to-postfix shunting-yard converter.
// Depends on itp_pkg and the infix_to_postfix_shunting_yard top level; nothing else.
`timescale 1ns / 1ps

module tb_infix_to_postfix_shunting_yard;
   import itp_pkg::*;

   localparam int STACK_SLOTS  = DEFAULT_STACK_DEPTH;
   localparam int RANDOM_ITEMS = 420;
   localparam int DRAIN_CYCLES = 20;

   // Encodings the block ignores.
   localparam kind_type TOK_UNUSED = 2'd3;
   localparam op_type   OP_UNUSED  = 3'd7;

   typedef struct packed {
      kind_type          kind;
      logic signed [31:0] value;
      op_type            op;
      err_type           err;
      logic              last;
   } postfix_tok_type;

   typedef struct packed {
      kind_type          kind;
      logic signed [31:0] value;
      op_type            code;
      logic              typed;
      postfix_tok_type   want;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_token_kind;
   logic signed [31:0] req_operand_value;
   logic [2:0]         req_operator_code;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_out_kind;
   logic signed [31:0] rsp_out_value;
   logic [2:0]         rsp_out_operator;
   logic [1:0]         rsp_error_code;
   logic               rsp_run_last;

   // Predictor state: a private copy of the operator stack.
   op_type          op_stack [STACK_SLOTS];
   int              op_depth;
   postfix_tok_type expected_postfix [$];
   int              results_of_last_token;
   int              tokens_counted;
   int              mismatch_count;
   bit              quiet;

   // Rows with the typed flag set replace the predicted result with the one written here.
   directed_row_type directed_rows [26] = '{
      '{TOK_OPERAND, 32'sh7fff_ffff, '0, 1'b1,
        '{OUT_OPERAND, 32'sh7fff_ffff, '0, ERR_NONE, 1'b1}},
      '{TOK_OPERAND, 32'sh8000_0000, '0, 1'b1,
        '{OUT_OPERAND, 32'sh8000_0000, '0, ERR_NONE, 1'b1}},
      '{TOK_OPERAND, 32'shffff_ffff, OP_UNUSED, 1'b1,
        '{OUT_OPERAND, 32'shffff_ffff, '0, ERR_NONE, 1'b1}},
      '{TOK_OPERATOR, '0, OP_CLOSE, 1'b1,
        '{OUT_ERROR, '0, '0, ERR_UNMATCH, 1'b1}},
      '{TOK_END, '0, '0, 1'b1,
        '{OUT_END, '0, '0, ERR_NONE, 1'b1}},
      '{TOK_OPERATOR, '0, OP_UNUSED, 1'b0, '0},
      '{TOK_UNUSED, 32'sh1234_5678, OP_OPEN, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_OPEN, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_OPEN, 1'b0, '0},
      '{TOK_OPERAND, 32'sd9, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_MINUS, 1'b0, '0},
      '{TOK_OPERAND, 32'sd8, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_CLOSE, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_POWER, 1'b0, '0},
      '{TOK_OPERAND, 32'sd7, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_POWER, 1'b0, '0},
      '{TOK_OPERAND, 32'sd6, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_TIMES, 1'b0, '0},
      '{TOK_OPERAND, 32'sd5, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_DIVIDE, 1'b0, '0},
      '{TOK_OPERAND, 32'sd4, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_PLUS, 1'b0, '0},
      '{TOK_OPERAND, 32'sd3, '0, 1'b0, '0},
      '{TOK_END, '0, '0, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_PLUS, 1'b0, '0},
      '{TOK_OPERATOR, '0, OP_CLOSE, 1'b0, '0}
   };

   infix_to_postfix_shunting_yard dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_token_kind    (req_token_kind),
      .req_operand_value (req_operand_value),
      .req_operator_code (req_operator_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_operator  (rsp_out_operator),
      .rsp_error_code    (rsp_error_code),
      .rsp_run_last      (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int binding_strength(op_type code);
      if (code == OP_POWER) return 3;
      if (code == OP_TIMES || code == OP_DIVIDE) return 2;
      return 1;
   endfunction

   function automatic void emit_postfix(kind_type kind, logic signed [31:0] value,
                                        op_type op, err_type err);
      postfix_tok_type t;
      t = '{kind, value, op, err, 1'b0};
      expected_postfix.push_back(t);
      results_of_last_token++;
   endfunction

   function automatic void pop_to_output();
      op_depth--;
      emit_postfix(OUT_OPERATOR, '0, op_stack[op_depth], ERR_NONE);
   endfunction

   // Works out the postfix tokens released by one accepted infix token.
   function automatic void predict_postfix(kind_type kind, logic signed [31:0] value,
                                           op_type code);
      bit              found;
      bit              left_assoc;
      int              mine;
      int              theirs;
      postfix_tok_type t;
      results_of_last_token = 0;
      if (kind == TOK_OPERAND) begin
         emit_postfix(OUT_OPERAND, value, '0, ERR_NONE);
      end else if (kind == TOK_END) begin
         while (op_depth > 0) pop_to_output();
         emit_postfix(OUT_END, '0, '0, ERR_NONE);
      end else if (kind == TOK_OPERATOR) begin
         if (code == OP_OPEN) begin
            if (op_depth >= STACK_SLOTS) begin
               emit_postfix(OUT_ERROR, '0, '0, ERR_OVERFLOW);
            end else begin
               op_stack[op_depth] = code;
               op_depth++;
            end
         end else if (code == OP_CLOSE) begin
            found = 1'b0;
            while (op_depth > 0 && !found) begin
               if (op_stack[op_depth-1] == OP_OPEN) begin
                  op_depth--;
                  found = 1'b1;
               end else begin
                  pop_to_output();
               end
            end
            if (!found) emit_postfix(OUT_ERROR, '0, '0, ERR_UNMATCH);
         end else if (code <= OP_POWER) begin
            mine = binding_strength(code);
            left_assoc = (code != OP_POWER);
            while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN) begin
               theirs = binding_strength(op_stack[op_depth-1]);
               if (theirs > mine || (theirs == mine && left_assoc)) pop_to_output();
               else break;
            end
            if (op_depth >= STACK_SLOTS) begin
               emit_postfix(OUT_ERROR, '0, '0, ERR_OVERFLOW);
            end else begin
               op_stack[op_depth] = code;
               op_depth++;
            end
         end
      end
      if (results_of_last_token > 0) begin
         t = expected_postfix.pop_back();
         t.last = 1'b1;
         expected_postfix.push_back(t);
      end
   endfunction

   // Presents one token, waits for its transfer and predicts what it releases.
   task automatic send_token(kind_type kind, logic signed [31:0] value, op_type code);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_token_kind    <= kind;
      req_operand_value <= value;
      req_operator_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_postfix(kind, value, code);
      if (kind != TOK_UNUSED && !(kind == TOK_OPERATOR && code == OP_UNUSED))
         tokens_counted++;
   endtask

   // Holds the sender idle until every result is in.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_postfix.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed expressions with random operands, operators and nesting.
   task automatic send_expression(int nest_cap, int terms);
      int open_now;
      open_now = 0;
      for (int i = 0; i < terms; i++) begin
         while (open_now < nest_cap && $urandom_range(3) == 0) begin
            send_token(TOK_OPERATOR, $urandom, OP_OPEN);
            open_now++;
         end
         send_token(TOK_OPERAND, $urandom, op_type'($urandom_range(7)));
         while (open_now > 0 && $urandom_range(2) == 0) begin
            send_token(TOK_OPERATOR, $urandom, OP_CLOSE);
            open_now--;
         end
         if (i < terms - 1)
            send_token(TOK_OPERATOR, $urandom, op_type'($urandom_range(OP_POWER)));
      end
      // Now and then leave a paren open or close one too many.
      if ($urandom_range(4) != 0) begin
         while (open_now > 0) begin
            send_token(TOK_OPERATOR, $urandom, OP_CLOSE);
            open_now--;
         end
      end
      if ($urandom_range(9) == 0) send_token(TOK_OPERATOR, $urandom, OP_CLOSE);
      send_token(TOK_END, $urandom, op_type'($urandom_range(7)));
   endtask

   // Nests parens close to or past the stack depth so that pushes can overflow.
   task automatic send_deep_nest();
      repeat ($urandom_range(30, STACK_SLOTS + 2))
         send_token(TOK_OPERATOR, $urandom, OP_OPEN);
      send_token(TOK_OPERAND, $urandom, op_type'($urandom_range(7)));
      repeat ($urandom_range(1, 4)) begin
         send_token(TOK_OPERATOR, $urandom, op_type'($urandom_range(OP_POWER)));
         send_token(TOK_OPERAND, $urandom, op_type'($urandom_range(7)));
      end
      repeat ($urandom_range(0, 3)) send_token(TOK_OPERATOR, $urandom, OP_CLOSE);
      send_token(TOK_END, $urandom, op_type'($urandom_range(7)));
   endtask

   initial begin
      op_depth       = 0;
      tokens_counted = 0;
      mismatch_count = 0;
      quiet          = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_token_kind    <= TOK_OPERAND;
      req_operand_value <= '0;
      req_operator_code <= OP_PLUS;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_token(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].code);
         if (directed_rows[i].typed) begin
            repeat (results_of_last_token) void'(expected_postfix.pop_back());
            expected_postfix.push_back(directed_rows[i].want);
         end
      end
      wait_drained();

      tokens_counted = 0;
      while (tokens_counted < RANDOM_ITEMS) begin
         quiet = (tokens_counted >= 200 && tokens_counted < 290);
         case ($urandom_range(9))
            0: send_deep_nest();
            1, 2: repeat ($urandom_range(1, 6))
                     send_token(kind_type'($urandom_range(3)), $urandom,
                                op_type'($urandom_range(7)));
            default: send_expression($urandom_range(0, 4), $urandom_range(1, 8));
         endcase
         if ($urandom_range(29) == 0) wait_drained();
      end
      quiet = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   always @(posedge clock) begin : check_postfix
      postfix_tok_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_postfix.size() == 0) begin
               $error("unexpected result transfer: out_kind %0d", rsp_out_kind);
               mismatch_count++;
            end else begin
               want = expected_postfix.pop_front();
               if (rsp_out_kind !== want.kind) begin
                  $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind);
                  mismatch_count++;
               end
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
                  mismatch_count++;
               end
               if (rsp_out_operator !== want.op) begin
                  $error("out_operator: expected %0d, got %0d", want.op, rsp_out_operator);
                  mismatch_count++;
               end
               if (rsp_error_code !== want.err) begin
                  $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
                  mismatch_count++;
               end
               if (rsp_run_last !== want.last) begin
                  $error("run_last: expected %0d, got %0d", want.last, rsp_run_last);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 8);
      end
   end

endmodule

/* filelist.f */
rtl/itp_pkg.sv
rtl/itp_stack_mem.sv
rtl/infix_to_postfix_shunting_yard.sv
test/tb_infix_to_postfix_shunting_yard.sv
